// ===== rtl/sm4_pkg.sv =====
// sm4 package: s-box, constants and round functions
`default_nettype none
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned RoundIdxW = 5;

  localparam logic [2:0] RegKeyHigh = 3'd0;
  localparam logic [2:0] RegKeyLow  = 3'd1;

  localparam logic [31:0] Fk0 = 32'ha3b1bac6;
  localparam logic [31:0] Fk1 = 32'h56aa3350;
  localparam logic [31:0] Fk2 = 32'h677d9197;
  localparam logic [31:0] Fk3 = 32'hb27022dc;

  localparam logic [7:0] Sbox [256] = '{
    8'hD6, 8'h90, 8'hE9, 8'hFE, 8'hCC, 8'hE1, 8'h3D, 8'hB7, 8'h16, 8'hB6, 8'h14, 8'hC2,
    8'h28, 8'hFB, 8'h2C, 8'h05, 8'h2B, 8'h67, 8'h9A, 8'h76, 8'h2A, 8'hBE, 8'h04, 8'hC3,
    8'hAA, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99, 8'h9C, 8'h42, 8'h50, 8'hF4,
    8'h91, 8'hEF, 8'h98, 8'h7A, 8'h33, 8'h54, 8'h0B, 8'h43, 8'hED, 8'hCF, 8'hAC, 8'h62,
    8'hE4, 8'hB3, 8'h1C, 8'hA9, 8'hC9, 8'h08, 8'hE8, 8'h95, 8'h80, 8'hDF, 8'h94, 8'hFA,
    8'h75, 8'h8F, 8'h3F, 8'hA6, 8'h47, 8'h07, 8'hA7, 8'hFC, 8'hF3, 8'h73, 8'h17, 8'hBA,
    8'h83, 8'h59, 8'h3C, 8'h19, 8'hE6, 8'h85, 8'h4F, 8'hA8, 8'h68, 8'h6B, 8'h81, 8'hB2,
    8'h71, 8'h64, 8'hDA, 8'h8B, 8'hF8, 8'hEB, 8'h0F, 8'h4B, 8'h70, 8'h56, 8'h9D, 8'h35,
    8'h1E, 8'h24, 8'h0E, 8'h5E, 8'h63, 8'h58, 8'hD1, 8'hA2, 8'h25, 8'h22, 8'h7C, 8'h3B,
    8'h01, 8'h21, 8'h78, 8'h87, 8'hD4, 8'h00, 8'h46, 8'h57, 8'h9F, 8'hD3, 8'h27, 8'h52,
    8'h4C, 8'h36, 8'h02, 8'hE7, 8'hA0, 8'hC4, 8'hC8, 8'h9E, 8'hEA, 8'hBF, 8'h8A, 8'hD2,
    8'h40, 8'hC7, 8'h38, 8'hB5, 8'hA3, 8'hF7, 8'hF2, 8'hCE, 8'hF9, 8'h61, 8'h15, 8'hA1,
    8'hE0, 8'hAE, 8'h5D, 8'hA4, 8'h9B, 8'h34, 8'h1A, 8'h55, 8'hAD, 8'h93, 8'h32, 8'h30,
    8'hF5, 8'h8C, 8'hB1, 8'hE3, 8'h1D, 8'hF6, 8'hE2, 8'h2E, 8'h82, 8'h66, 8'hCA, 8'h60,
    8'hC0, 8'h29, 8'h23, 8'hAB, 8'h0D, 8'h53, 8'h4E, 8'h6F, 8'hD5, 8'hDB, 8'h37, 8'h45,
    8'hDE, 8'hFD, 8'h8E, 8'h2F, 8'h03, 8'hFF, 8'h6A, 8'h72, 8'h6D, 8'h6C, 8'h5B, 8'h51,
    8'h8D, 8'h1B, 8'hAF, 8'h92, 8'hBB, 8'hDD, 8'hBC, 8'h7F, 8'h11, 8'hD9, 8'h5C, 8'h41,
    8'h1F, 8'h10, 8'h5A, 8'hD8, 8'h0A, 8'hC1, 8'h31, 8'h88, 8'hA5, 8'hCD, 8'h7B, 8'hBD,
    8'h2D, 8'h74, 8'hD0, 8'h12, 8'hB8, 8'hE5, 8'hB4, 8'hB0, 8'h89, 8'h69, 8'h97, 8'h4A,
    8'h0C, 8'h96, 8'h77, 8'h7E, 8'h65, 8'hB9, 8'hF1, 8'h09, 8'hC5, 8'h6E, 8'hC6, 8'h84,
    8'h18, 8'hF0, 8'h7D, 8'hEC, 8'h3A, 8'hDC, 8'h4D, 8'h20, 8'h79, 8'hEE, 8'h5F, 8'h3E,
    8'hD7, 8'hCB, 8'h39, 8'h48};

  function automatic logic [31:0] tau(input logic [31:0] v);
    tau = {Sbox[v[31:24]], Sbox[v[23:16]], Sbox[v[15:8]], Sbox[v[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
    rotl = (v << s) | (v >> (32 - s));
  endfunction

  function automatic logic [31:0] lin_data(input logic [31:0] b);
    lin_data = b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  function automatic logic [31:0] lin_key(input logic [31:0] b);
    lin_key = b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // ck byte j of round i is (4*i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [RoundIdxW-1:0] i);
    logic [7:0] b;
    logic [31:0] r;
    r = '0;
    for (int j = 0; j < 4; j++) begin
      b = 8'(({3'd0, i} * 8'd4 + 8'(j)) * 8'd7);
      r = {r[23:0], b};
    end
    ck_word = r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sm4_block_cipher.sv =====
// sm4 block cipher top level: apb key port, key expansion and round pipeline
// A block passes an input register and 32 round stages, and a new word can enter every cycle
// unless the output stalls or the round keys are being rebuilt. Each round stage does
// one round (s-box lookup and linear transform). After reset or a key register
// write the round keys are rebuilt one per cycle; meanwhile no word is accepted
// (in_ready_o low). Key writes must happen while the pipe is empty.
`default_nettype none
module sm4_block_cipher
  import sm4_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  input  wire logic        decrypt_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);

  logic [63:0] key_high_q, key_low_q;
  logic        wr_en;
  logic [2:0]  reg_idx;
  logic [31:0] rk_q [NumRounds];
  logic [31:0] kw_q [4];
  logic        busy_q;
  logic [RoundIdxW-1:0] kcnt_q;
  logic [31:0] kt, knew;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:3+0] == 1'b1 ? RegKeyLow : RegKeyHigh;
  assign wr_en   = psel && penable && pwrite;
  assign prdata  = (reg_idx == RegKeyLow) ? key_low_q : key_high_q;

  assign kt   = tau(kw_q[1] ^ kw_q[2] ^ kw_q[3] ^ ck_word(kcnt_q));
  assign knew = kw_q[0] ^ lin_key(kt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      busy_q     <= 1'b1;
      kcnt_q     <= '0;
      kw_q[0]    <= Fk0;
      kw_q[1]    <= Fk1;
      kw_q[2]    <= Fk2;
      kw_q[3]    <= Fk3;
    end else if (wr_en) begin
      busy_q <= 1'b1;
      kcnt_q <= '0;
      if (reg_idx == RegKeyLow) begin
        key_low_q <= pwdata;
        kw_q[0]   <= key_high_q[63:32] ^ Fk0;
        kw_q[1]   <= key_high_q[31:0] ^ Fk1;
        kw_q[2]   <= pwdata[63:32] ^ Fk2;
        kw_q[3]   <= pwdata[31:0] ^ Fk3;
      end else begin
        key_high_q <= pwdata;
        kw_q[0]    <= pwdata[63:32] ^ Fk0;
        kw_q[1]    <= pwdata[31:0] ^ Fk1;
        kw_q[2]    <= key_low_q[63:32] ^ Fk2;
        kw_q[3]    <= key_low_q[31:0] ^ Fk3;
      end
    end else if (busy_q) begin
      kw_q[0] <= kw_q[1];
      kw_q[1] <= kw_q[2];
      kw_q[2] <= kw_q[3];
      kw_q[3] <= knew;
      kcnt_q  <= kcnt_q + 1'b1;
      if (kcnt_q == RoundIdxW'(NumRounds - 1)) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q && !wr_en) rk_q[kcnt_q] <= knew;
  end

  // round pipeline
  logic        adv;
  logic        vld_q [NumRounds+1];
  logic        dec_q [NumRounds];
  logic [31:0] x_q [NumRounds+1][4];

  assign adv        = !vld_q[NumRounds] || out_ready_i;
  assign in_ready_o = adv && !busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s <= NumRounds; s++) vld_q[s] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i && !busy_q;
      for (int s = 1; s <= NumRounds; s++) vld_q[s] <= vld_q[s-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      x_q[0][0] <= block_high_i[63:32];
      x_q[0][1] <= block_high_i[31:0];
      x_q[0][2] <= block_low_i[63:32];
      x_q[0][3] <= block_low_i[31:0];
      dec_q[0]  <= decrypt_i;
      for (int s = 0; s < NumRounds; s++) begin
        if (s < NumRounds - 1) dec_q[s+1] <= dec_q[s];
        x_q[s+1][0] <= x_q[s][1];
        x_q[s+1][1] <= x_q[s][2];
        x_q[s+1][2] <= x_q[s][3];
        x_q[s+1][3] <= x_q[s][0] ^ lin_data(tau(x_q[s][1] ^ x_q[s][2] ^ x_q[s][3] ^
                       (dec_q[s] ? rk_q[NumRounds-1-s] : rk_q[s])));
      end
    end
  end

  assign out_valid_o   = vld_q[NumRounds];
  assign result_high_o = {x_q[NumRounds][3], x_q[NumRounds][2]};
  assign result_low_o  = {x_q[NumRounds][1], x_q[NumRounds][0]};

endmodule
`default_nettype wire

// ===== rtl/sm4_checker.sv =====
// port-level checker for the sm4 block cipher, bound to the top level
`default_nettype none
module sm4_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [63:0] result_high_o,
  input wire logic [63:0] result_low_o,
  input wire logic        pready
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_high_o)
      && $stable(result_low_o)) else $error("result dropped under stall");
  a_no_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o) else $error("input taken with full pipe");
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i) else $error("input word withdrawn");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");
  a_reset_idle: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("result after reset");
endmodule

bind sm4_block_cipher sm4_checker u_sm4_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .result_high_o(result_high_o),
  .result_low_o(result_low_o), .pready(pready)
);
`default_nettype wire

// ===== verif/sm4_block_cipher_test.sv =====
// testbench for sm4_block_cipher: random and directed blocks checked against a built-in sm4 model
`default_nettype none
module sm4_block_cipher_test;
  import sm4_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } block_t;

  class cipher_scoreboard;
    logic [63:0] key_hi, key_lo;
    logic [31:0] rk [32];
    block_t pending [$];
    int errors;

    function logic [31:0] sub_word(logic [31:0] v);
      logic [7:0] tbl [256];
      tbl = Sbox;
      return {tbl[v[31:24]], tbl[v[23:16]], tbl[v[15:8]], tbl[v[7:0]]};
    endfunction

    function logic [31:0] rot(logic [31:0] v, int s);
      return (v << s) | (v >> (32 - s));
    endfunction

    function void set_key(logic [63:0] hi, logic [63:0] lo);
      logic [31:0] k [4];
      logic [31:0] t, ck;
      key_hi = hi;
      key_lo = lo;
      k[0] = hi[63:32] ^ 32'ha3b1bac6;
      k[1] = hi[31:0] ^ 32'h56aa3350;
      k[2] = lo[63:32] ^ 32'h677d9197;
      k[3] = lo[31:0] ^ 32'hb27022dc;
      for (int i = 0; i < 32; i++) begin
        ck = '0;
        for (int j = 0; j < 4; j++) ck = {ck[23:0], 8'((4 * i + j) * 7)};
        t = sub_word(k[1] ^ k[2] ^ k[3] ^ ck);
        rk[i] = k[0] ^ t ^ rot(t, 13) ^ rot(t, 23);
        k[0] = k[1]; k[1] = k[2]; k[2] = k[3]; k[3] = rk[i];
      end
    endfunction

    function void note_block(block_t b, logic dec);
      logic [31:0] x [4];
      logic [31:0] t, n;
      block_t r;
      x[0] = b.hi[63:32]; x[1] = b.hi[31:0]; x[2] = b.lo[63:32]; x[3] = b.lo[31:0];
      for (int i = 0; i < 32; i++) begin
        t = sub_word(x[1] ^ x[2] ^ x[3] ^ (dec ? rk[31 - i] : rk[i]));
        n = x[0] ^ t ^ rot(t, 2) ^ rot(t, 10) ^ rot(t, 18) ^ rot(t, 24);
        x[0] = x[1]; x[1] = x[2]; x[2] = x[3]; x[3] = n;
      end
      r.hi = {x[3], x[2]};
      r.lo = {x[1], x[0]};
      pending.push_back(r);
    endfunction

    task report(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [63:0] hi, logic [63:0] lo);
      block_t e;
      if (pending.size() == 0) begin
        report($sformatf("unexpected word %h %h", hi, lo));
        return;
      end
      e = pending.pop_front();
      if (hi !== e.hi) report($sformatf("result_high %h, want %h", hi, e.hi));
      if (lo !== e.lo) report($sformatf("result_low %h, want %h", lo, e.lo));
    endtask
  endclass

  logic clk_i = 1'b0, rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [63:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid_i = 1'b0, in_ready_o, decrypt_i = 1'b0;
  logic [63:0] block_high_i = '0, block_low_i = '0;
  logic out_valid_o, out_ready_i = 1'b0;
  logic [63:0] result_high_o, result_low_o;

  cipher_scoreboard sb = new();
  int send_idle, recv_idle;
  longint cycles;

  sm4_block_cipher u_dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("simulation failed");
      $finish;
    end
    if (out_valid_o && out_ready_i) sb.check_result(result_high_o, result_low_o);
  end

  always @(negedge clk_i) out_ready_i <= ($urandom_range(99) >= recv_idle);

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx[0], 3'b000}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == RegKeyHigh) sb.set_key(v, sb.key_lo);
    else if (idx == RegKeyLow) sb.set_key(sb.key_hi, v);
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_block(logic [63:0] hi, logic [63:0] lo, logic dec);
    block_t b;
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1; block_high_i <= hi; block_low_i <= lo; decrypt_i <= dec;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    b.hi = hi;
    b.lo = lo;
    sb.note_block(b, dec);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  initial begin
    logic [63:0] h, l;
    logic d;
    int pick;
    sb.set_key('0, '0);
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    send_idle = 0;
    recv_idle = 0;
    // field extremes under the reset key, encrypted and decrypted
    send_block('0, '0, 1'b0);
    send_block('1, '1, 1'b0);
    send_block('0, '0, 1'b1);
    send_block('1, '1, 1'b1);
    drain();
    write_reg(RegKeyHigh, 64'h0123456789abcdef);
    write_reg(RegKeyLow, 64'hfedcba9876543210);
    send_block(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0);
    send_block(64'h681edf34d206965e, 64'h86b3e94f536e4246, 1'b1);
    send_block(64'h8000000000000000, 64'h0000000000000001, 1'b0);
    drain();
    send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0);
    drain();
    write_reg(RegKeyHigh, '1);
    send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1);
    drain();
    write_reg(RegKeyLow, '1);
    send_block('1, '0, 1'b0);
    send_block('0, '1, 1'b1);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      send_idle = (ph % 3 == 0) ? 28 : (ph % 3 == 1) ? 67 : 0;
      recv_idle = (ph % 3 == 0) ? 67 : (ph % 3 == 1) ? 28 : 0;
      write_reg(RegKeyHigh, (ph == 5) ? '0 : rand64());
      write_reg(RegKeyLow, (ph == 5) ? '0 : rand64());
      for (int n = 0; n < 215; n++) begin
        pick = $urandom_range(9);
        h = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
        l = (pick == 2) ? '0 : (pick == 3) ? '1 : rand64();
        d = $urandom_range(1);
        send_block(h, l, d);
      end
      drain();
    end
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
